FILE: design/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants of the critically damped 2D smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

    // bit-serial multiplier: 64-bit multiplicand, 34-bit multiplier
    localparam int MUL_A_W  = 64;
    localparam int MUL_B_W  = 34;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // restoring divider: quotient known to fit in DIV_Q_W bits
    localparam int DIV_N_W  = 76;
    localparam int DIV_D_W  = 47;
    localparam int DIV_Q_W  = 34;

    // digit-by-digit square root
    localparam int SQRT_N_W = 64;
    localparam int SQRT_R_W = SQRT_N_W / 2;

    // configuration port
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 1'b1;

    // polynomial coefficients, Q0.16
    localparam logic [14:0] K048  = 15'd31457;
    localparam logic [14:0] K0235 = 15'd15401;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic        [15:0] step_time;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
    } out_t;

endpackage

`default_nettype wire

FILE: design/critically_damped_smoother_2d.sv
// ----------------------------------------------------------------------------
// critically_damped_smoother_2d
// Critically damped spring smoother for a 2D position with kept velocity.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_ready  | in_data  : cur, goal, step_time
//  out      | out_valid / out_ready| out_data : out pos, speed
//  cfg      | cfg_we               | cfg_index, cfg_data (no read-back)
//
//  A transaction runs 24 to 26 products through the one shared bit-serial
//  multiplier, 2 or 3 divisions and one square root, one after the other;
//  the larger counts apply when the offset is clamped.
//  No clearing pass after reset; velocity resets to zero.
//  in_ready is high only while idle; the finished result sits in an output
//  register, so the next transaction may start while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module critically_damped_smoother_2d (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cds_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cds_pkg::out_t                      out_data,
    input  wire logic                          cfg_we,
    input  wire logic [cds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cds_pkg::CFG_W-1:0]     cfg_data
);

    localparam int A_W   = cds_pkg::MUL_A_W;
    localparam int B_W   = cds_pkg::MUL_B_W;
    localparam int P_W   = cds_pkg::MUL_P_W;
    localparam int N_W   = cds_pkg::DIV_N_W;
    localparam int D_W   = cds_pkg::DIV_D_W;
    localparam int Q_W   = cds_pkg::DIV_Q_W;
    localparam int S_W_N = cds_pkg::SQRT_N_W;
    localparam int R_W   = cds_pkg::SQRT_R_W;
    localparam int ACC_W = 67;            // holds every signed partial sum
    localparam int MAG_W = ACC_W - 1;

    localparam logic [46:0] T3_LIM  = 47'h4000_0000_0000;    // 2^46
    localparam logic [30:0] ST_MIN  = 31'd7;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // one entry per operation of the shared units
    typedef enum logic [4:0] {
        S_OMEGA, S_A, S_A2, S_T2, S_P3, S_T3, S_E, S_DE, S_AE, S_MC,
        S_SQ, S_SQRT, S_R, S_CL, S_W, S_NV1, S_NV2, S_O1, S_O2, S_O3, S_DOT
    } step_t;

    // ---------------------------------------------------------------- regs
    state_t state_reg;
    step_t  step_reg;
    step_t  step_next;
    logic   ax_reg;
    logic   ax_next;
    logic   last_op;

    logic [30:0] smooth_time_reg;
    logic [30:0] max_speed_reg;
    logic signed [31:0] vel_reg [2];

    logic               out_valid_reg;
    cds_pkg::out_t      out_data_reg;

    logic signed [31:0] cur_reg  [2];
    logic signed [31:0] goal_reg [2];
    logic [15:0]        dt_reg;
    logic [30:0]        st_reg;
    logic [30:0]        omega_reg;
    logic [30:0]        a_reg;
    logic [45:0]        a2_reg;
    logic [44:0]        t2_reg;
    logic [43:0]        p3_reg;
    logic [46:0]        t3_reg;
    logic [32:0]        e_reg;
    logic [31:0]        de_reg;
    logic [30:0]        ae_reg;
    logic [45:0]        mc_reg;
    logic [32:0]        umag_reg [2];
    logic               csgn_reg [2];
    logic [62:0]        sq_reg;
    logic [32:0]        mag_reg;
    logic [29:0]        r_reg;
    logic signed [ACC_W-1:0] w_reg;
    logic signed [ACC_W-1:0] nv_reg;
    logic signed [ACC_W-1:0] o_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic signed [31:0] rpos_reg [2];
    logic signed [31:0] rvel_reg [2];

    // ---------------------------------------------------------------- units
    logic            mul_start, div_start, sqrt_start;
    logic            mul_done, div_done, sqrt_done;
    logic [A_W-1:0]  mul_a;
    logic [B_W-1:0]  mul_b;
    logic [P_W-1:0]  mul_prod;
    logic [N_W-1:0]  div_n;
    logic [D_W-1:0]  div_d;
    logic [Q_W-1:0]  div_q;
    logic [S_W_N-1:0] sqrt_n;
    logic [R_W-1:0]  sqrt_root;
    logic            is_mul, is_div, is_sqrt;
    logic            unit_done;
    logic            wb;

    cds_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    cds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_n),
        .denom (div_d),
        .done  (div_done),
        .quot  (div_q)
    );

    cds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_n),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // ------------------------------------------------------------- helpers
    function automatic logic signed [ACC_W-1:0] smag(input logic neg,
                                                     input logic [MAG_W-1:0] m);
        logic signed [ACC_W-1:0] v;
        v    = $signed({1'b0, m});
        smag = neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] hi;
        hi = v[ACC_W-1:31];
        if (hi == '0 || hi == '1)
            sat32 = v[31:0];
        else if (v[ACC_W-1])
            sat32 = 32'sh8000_0000;
        else
            sat32 = 32'sh7FFF_FFFF;
    endfunction

    // per-axis views, selected by ax_reg
    logic signed [31:0] cur_s, goal_s, vel_s, rpos_s;
    logic [32:0]        umag_s;
    logic               csgn_s;
    logic               vneg, wneg;
    logic [31:0]        vabs;
    logic [MAG_W-1:0]   wabs;
    logic signed [32:0] d1, d2;
    logic [32:0]        d1abs, d2abs;
    logic               k_shift;
    logic [31:0]        ushr;
    logic [32:0]        mag_new;
    logic [46:0]        den;
    logic [81:0]        t3_hi;
    logic [46:0]        t3_new;
    logic signed [ACC_W-1:0] o_fin;
    logic signed [ACC_W-1:0] dot_term;
    logic               over;

    assign cur_s  = cur_reg[ax_reg];
    assign goal_s = goal_reg[ax_reg];
    assign vel_s  = vel_reg[ax_reg];
    assign rpos_s = rpos_reg[ax_reg];
    assign umag_s = umag_reg[ax_reg];
    assign csgn_s = csgn_reg[ax_reg];

    assign vneg  = vel_s[31];
    assign vabs  = vneg ? 32'(-{1'b1, vel_s}) : 32'(vel_s);
    assign wneg  = w_reg[ACC_W-1];
    assign wabs  = wneg ? MAG_W'(-w_reg) : MAG_W'(w_reg);

    assign d1    = 33'(goal_s) - 33'(cur_s);
    assign d2    = 33'(rpos_s) - 33'(goal_s);
    assign d1abs = d1[32] ? 33'(-d1) : 33'(d1);
    assign d2abs = d2[32] ? 33'(-d2) : 33'(d2);

    // halve both axes when either offset reaches 2^31 so the squares fit
    assign k_shift = (umag_reg[0][32:31] != 2'b00) || (umag_reg[1][32:31] != 2'b00);
    assign ushr    = k_shift ? umag_s[32:1] : umag_s[31:0];
    assign mag_new = k_shift ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};

    assign den    = 47'd65536 + 47'(a_reg) + 47'(t2_reg) + t3_reg;
    assign t3_hi  = mul_prod[P_W-1:16];
    assign t3_new = (t3_hi > 82'(T3_LIM)) ? T3_LIM : t3_hi[46:0];

    assign o_fin    = o_reg + smag(csgn_s, MAG_W'(mul_prod[63:16]));
    assign dot_term = smag(d1[32] ^ d2[32], MAG_W'(mul_prod[64:0]));
    assign over     = !dot_reg[ACC_W-1] && (dot_reg != '0);

    // --------------------------------------------------------- unit select
    always_comb
    begin
        is_mul  = 1'b0;
        is_div  = 1'b0;
        is_sqrt = 1'b0;
        case (step_reg) inside
            S_OMEGA, S_E, S_R: is_div  = 1'b1;
            S_SQRT:            is_sqrt = 1'b1;
            default:           is_mul  = 1'b1;
        endcase
    end

    assign unit_done  = is_div ? div_done : (is_sqrt ? sqrt_done : mul_done);
    assign wb         = (state_reg == ST_WAIT) && unit_done;
    assign mul_start  = (state_reg == ST_ISSUE) && is_mul;
    assign div_start  = (state_reg == ST_ISSUE) && is_div;
    assign sqrt_start = (state_reg == ST_ISSUE) && is_sqrt;

    // ------------------------------------------------------ operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        div_n  = '0;
        div_d  = '0;
        sqrt_n = S_W_N'(sq_reg);
        case (step_reg)
            S_OMEGA: begin div_n = N_W'(1) << 33; div_d = D_W'(st_reg); end
            S_A:     begin mul_a = A_W'(omega_reg); mul_b = B_W'(dt_reg); end
            S_A2:    begin mul_a = A_W'(a_reg);     mul_b = B_W'(a_reg); end
            S_T2:    begin mul_a = A_W'(a2_reg);    mul_b = B_W'(cds_pkg::K048); end
            S_P3:    begin mul_a = A_W'(a2_reg);    mul_b = B_W'(cds_pkg::K0235); end
            S_T3:    begin mul_a = A_W'(p3_reg);    mul_b = B_W'(a_reg); end
            S_E:     begin div_n = N_W'(1) << 48;   div_d = den; end
            S_DE:    begin mul_a = A_W'(e_reg);     mul_b = B_W'(dt_reg); end
            S_AE:    begin mul_a = A_W'(e_reg);     mul_b = B_W'(a_reg); end
            S_MC:    begin mul_a = A_W'(max_speed_reg); mul_b = B_W'(st_reg); end
            S_SQ:    begin mul_a = A_W'(ushr);      mul_b = B_W'(ushr); end
            S_R:     begin div_n = {mc_reg, 30'd0}; div_d = D_W'(mag_reg); end
            S_CL:    begin mul_a = A_W'(umag_s);    mul_b = B_W'(r_reg); end
            S_W:     begin mul_a = A_W'(umag_s);    mul_b = B_W'(omega_reg); end
            S_NV1:   begin mul_a = A_W'(e_reg);     mul_b = B_W'(vabs); end
            S_NV2:   begin mul_a = A_W'(wabs);      mul_b = B_W'(ae_reg); end
            S_O1:    begin mul_a = A_W'(e_reg);     mul_b = B_W'(umag_s); end
            S_O2:    begin mul_a = A_W'(de_reg);    mul_b = B_W'(vabs); end
            S_O3:    begin mul_a = A_W'(umag_s);    mul_b = B_W'(ae_reg); end
            S_DOT:   begin mul_a = A_W'(d1abs);     mul_b = B_W'(d2abs); end
            default: begin mul_a = '0; end
        endcase
    end

    // ----------------------------------------------------------- sequence
    always_comb
    begin
        step_next = step_reg;
        ax_next   = ax_reg;
        last_op   = 1'b0;
        case (step_reg)
            S_OMEGA: step_next = S_A;
            S_A:     step_next = S_A2;
            S_A2:    step_next = S_T2;
            S_T2:    step_next = S_P3;
            S_P3:    step_next = S_T3;
            S_T3:    step_next = S_E;
            S_E:     step_next = S_DE;
            S_DE:    step_next = S_AE;
            S_AE:    step_next = S_MC;
            S_MC:    begin step_next = S_SQ; ax_next = 1'b0; end
            S_SQ:    begin step_next = ax_reg ? S_SQRT : S_SQ; ax_next = !ax_reg; end
            S_SQRT:  begin
                         step_next = (46'(mag_new) > mc_reg) ? S_R : S_W;
                         ax_next   = 1'b0;
                     end
            S_R:     begin step_next = S_CL; ax_next = 1'b0; end
            S_CL:    begin step_next = ax_reg ? S_W : S_CL; ax_next = !ax_reg; end
            S_W:     step_next = S_NV1;
            S_NV1:   step_next = S_NV2;
            S_NV2:   step_next = S_O1;
            S_O1:    step_next = S_O2;
            S_O2:    step_next = S_O3;
            S_O3:    begin step_next = ax_reg ? S_DOT : S_W; ax_next = !ax_reg; end
            S_DOT:   begin last_op = ax_reg; ax_next = !ax_reg; end
            default: step_next = S_OMEGA;
        endcase
    end

    // ------------------------------------------------------------ control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= S_OMEGA;
            ax_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            vel_reg[0]      <= '0;
            vel_reg[1]      <= '0;
            smooth_time_reg <= 31'd65536;
            max_speed_reg   <= 31'h7FFF_FFFF;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cds_pkg::REG_SMOOTH_TIME: smooth_time_reg <= cfg_data;
                    cds_pkg::REG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                endcase
            end

            // a new result may replace the one taken in the same cycle
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_ISSUE;
                        step_reg  <= S_OMEGA;
                        ax_reg    <= 1'b0;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        step_reg  <= step_next;
                        ax_reg    <= ax_next;
                        state_reg <= last_op ? ST_DONE : ST_ISSUE;
                    end
                end
                ST_DONE:
                begin
                    // overshoot snaps onto the goal and kills the velocity
                    if (!out_valid_reg || out_ready)
                    begin
                        vel_reg[0]    <= over ? 32'sd0 : rvel_reg[0];
                        vel_reg[1]    <= over ? 32'sd0 : rvel_reg[1];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cur_reg[0]  <= in_data.cur_x;
            cur_reg[1]  <= in_data.cur_y;
            goal_reg[0] <= in_data.goal_x;
            goal_reg[1] <= in_data.goal_y;
            dt_reg      <= in_data.step_time;
            st_reg      <= (smooth_time_reg < ST_MIN) ? ST_MIN : smooth_time_reg;
            umag_reg[0] <= (33'(in_data.cur_x) < 33'(in_data.goal_x))
                         ? 33'(33'(in_data.goal_x) - 33'(in_data.cur_x))
                         : 33'(33'(in_data.cur_x) - 33'(in_data.goal_x));
            umag_reg[1] <= (33'(in_data.cur_y) < 33'(in_data.goal_y))
                         ? 33'(33'(in_data.goal_y) - 33'(in_data.cur_y))
                         : 33'(33'(in_data.cur_y) - 33'(in_data.goal_y));
            csgn_reg[0] <= in_data.cur_x < in_data.goal_x;
            csgn_reg[1] <= in_data.cur_y < in_data.goal_y;
        end

        if (wb)
        begin
            case (step_reg)
                S_OMEGA: omega_reg <= div_q[30:0];
                S_A:     a_reg     <= mul_prod[46:16];
                S_A2:    a2_reg    <= mul_prod[61:16];
                S_T2:    t2_reg    <= mul_prod[60:16];
                S_P3:    p3_reg    <= mul_prod[59:16];
                S_T3:    t3_reg    <= t3_new;
                S_E:     e_reg     <= div_q[32:0];
                S_DE:    de_reg    <= mul_prod[47:16];
                S_AE:    ae_reg    <= mul_prod[62:32];
                S_MC:    mc_reg    <= mul_prod[61:16];
                S_SQ:    sq_reg    <= ax_reg ? 63'(sq_reg + mul_prod[62:0])
                                             : mul_prod[62:0];
                S_SQRT:  mag_reg   <= mag_new;
                S_R:     r_reg     <= div_q[29:0];
                S_CL:    umag_reg[ax_reg] <= mul_prod[62:30];
                S_W:     w_reg  <= ACC_W'(vel_s) + smag(csgn_s, MAG_W'(mul_prod[63:16]));
                S_NV1:   nv_reg <= smag(vneg, MAG_W'(mul_prod[63:32]));
                S_NV2:   nv_reg <= nv_reg - smag(wneg, MAG_W'(mul_prod[63:16]));
                S_O1:    o_reg  <= ACC_W'(cur_s) - smag(csgn_s, MAG_W'(umag_s))
                                 + smag(csgn_s, MAG_W'(mul_prod[63:32]));
                S_O2:    o_reg  <= o_reg + smag(vneg, MAG_W'(mul_prod[63:32]));
                S_O3:
                begin
                    rpos_reg[ax_reg] <= sat32(o_fin);
                    rvel_reg[ax_reg] <= sat32(nv_reg);
                end
                S_DOT:   dot_reg <= ax_reg ? dot_reg + dot_term : dot_term;
                default: dot_reg <= dot_reg;
            endcase
        end

        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_data_reg.out_x   <= over ? goal_reg[0] : rpos_reg[0];
            out_data_reg.out_y   <= over ? goal_reg[1] : rpos_reg[1];
            out_data_reg.speed_x <= over ? 32'sd0 : rvel_reg[0];
            out_data_reg.speed_y <= over ? 32'sd0 : rvel_reg[1];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // --------------------------------------------------------- assertions
    a_one_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, div_done, sqrt_done}))
        else $error("more than one arithmetic unit finished at once");

    a_t3_limited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && step_reg == S_E) |-> (t3_reg <= T3_LIM))
        else $error("cubic term above its limit");

    a_clamp_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && step_reg == S_CL && mul_done)
            |-> (mul_prod[P_W-1:30] <= (P_W-30)'(umag_s)))
        else $error("offset clamp grew an offset");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without finishing a transaction");

endmodule

`default_nettype wire

FILE: design/cds_mul.sv
// ----------------------------------------------------------------------------
// cds_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [cds_pkg::MUL_A_W-1:0] mcand,
    input  wire logic [cds_pkg::MUL_B_W-1:0] mplier,
    output logic                             done,
    output logic [cds_pkg::MUL_P_W-1:0]      prod
);

    localparam int A_W   = cds_pkg::MUL_A_W;
    localparam int B_W   = cds_pkg::MUL_B_W;
    localparam int P_W   = cds_pkg::MUL_P_W;
    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [A_W-1:0]   mcand_reg;
    logic [A_W:0]     sum;

    assign sum      = {1'b0, acc_reg[P_W-1:B_W]}
                    + (acc_reg[0] ? {1'b0, mcand_reg} : {(A_W+1){1'b0}});
    assign acc_next = {sum, acc_reg[B_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{A_W{1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

FILE: design/cds_div.sv
// ----------------------------------------------------------------------------
// cds_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [cds_pkg::DIV_N_W-1:0] numer,
    input  wire logic [cds_pkg::DIV_D_W-1:0] denom,
    output logic                             done,
    output logic [cds_pkg::DIV_Q_W-1:0]      quot
);

    localparam int N_W   = cds_pkg::DIV_N_W;
    localparam int D_W   = cds_pkg::DIV_D_W;
    localparam int Q_W   = cds_pkg::DIV_Q_W;
    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q_next;
    logic [D_W-1:0]   d_reg;
    logic [D_W:0]     trial;
    logic             ge;

    // top bits of the numerator are below the divisor, so start from them
    assign trial    = {rem_reg, q_reg[Q_W-1]};
    assign ge       = trial >= {1'b0, d_reg};
    assign rem_next = ge ? D_W'(trial - {1'b0, d_reg}) : trial[D_W-1:0];
    assign q_next   = {q_reg[Q_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= D_W'(numer[N_W-1:Q_W]);
            q_reg   <= numer[Q_W-1:0];
            d_reg   <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

FILE: design/cds_sqrt.sv
// ----------------------------------------------------------------------------
// cds_sqrt
// Integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [cds_pkg::SQRT_N_W-1:0] radicand,
    output logic                              done,
    output logic [cds_pkg::SQRT_R_W-1:0]      root
);

    localparam int N_W   = cds_pkg::SQRT_N_W;
    localparam int R_W   = cds_pkg::SQRT_R_W;
    localparam int REM_W = R_W + 2;
    localparam int CNT_W = $clog2(R_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(R_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   n_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [R_W-1:0]   root_reg;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign rem2     = {rem_reg, n_reg[N_W-1:N_W-2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign ge       = rem2 >= trial;
    assign rem_next = ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[N_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[R_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
